>>> rtl/core/brf_pkg.sv
`timescale 1ns / 1ps

package brf_pkg;

  localparam int DEPTH       = 256;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int POS_W       = ADDR_W + 1;
  localparam int MAX_GET     = 64;
  localparam int GET_W       = 7;
  localparam int BYTE_W      = 8;
  localparam int FILL_W      = 9;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - BYTE_W - FILL_W - 1;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

endpackage

>>> rtl/core/byte_ring_fifo_core.sv
`timescale 1ns / 1ps

// Channel | Direction | tdata (low bit up)                        | tuser                 | tlast
// in_     | slave     | data_in[7:0], get_count[14:8]             | cmd                   | -
// out_    | master    | data_out[7:0], fill_count[16:8], is_full  | data_valid, accepted  | last
//
// A put, or a get that yields no byte, produces one item.
// A get of n bytes produces n items: each byte is read on the store's single
// read port in ST_RD and then loaded into the output register in ST_EM.
// Reset (rst_n low, synchronous) clears both positions and the output valid;
// the byte store holds no reset. A stalled output holds the block; no new
// input item is taken until the current one has produced all its items.
module byte_ring_fifo_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [brf_pkg::IN_TDATA_W-1:0]    in_tdata,   // data_in[7:0], get_count[14:8]
  input  logic                              in_tuser,   // cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [brf_pkg::OUT_TDATA_W-1:0]   out_tdata,  // data_out, fill_count, is_full
  output logic [1:0]                        out_tuser,  // data_valid, accepted
  output logic                              out_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EM   = 2'd2;

  logic [brf_pkg::BYTE_W-1:0] mem [brf_pkg::DEPTH];
  logic [brf_pkg::BYTE_W-1:0] rdata_r;

  logic [1:0]                 state_r, state_nxt;
  logic [brf_pkg::POS_W-1:0]  wp_r, wp_nxt;
  logic [brf_pkg::POS_W-1:0]  rp_r, rp_nxt;
  logic [brf_pkg::GET_W-1:0]  cnt_r, cnt_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [brf_pkg::BYTE_W-1:0] out_data_r, out_data_nxt;
  logic                       out_dv_r, out_dv_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_acc_r, out_acc_nxt;
  logic [brf_pkg::FILL_W-1:0] out_fill_r, out_fill_nxt;

  logic                       slot_free;
  logic                       in_acc;
  logic                       put_we;
  logic [brf_pkg::BYTE_W-1:0] din;
  logic [brf_pkg::GET_W-1:0]  want, want_sat, n_get;
  logic [brf_pkg::POS_W-1:0]  fill_now, rp_inc, wp_inc;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;
  assign din       = in_tdata[brf_pkg::BYTE_W-1:0];
  assign want      = in_tdata[brf_pkg::BYTE_W +: brf_pkg::GET_W];
  assign fill_now  = wp_r - rp_r;
  assign rp_inc    = rp_r + 1'b1;
  assign wp_inc    = wp_r + 1'b1;

  // clamp the request to MAX_GET, then to what is stored
  assign want_sat = (want > brf_pkg::GET_W'(brf_pkg::MAX_GET)) ?
                    brf_pkg::GET_W'(brf_pkg::MAX_GET) : want;
  assign n_get    = (fill_now < brf_pkg::POS_W'(want_sat)) ?
                    brf_pkg::GET_W'(fill_now) : want_sat;

  assign put_we = in_acc && (in_tuser == brf_pkg::CMD_PUT) &&
                  (fill_now != brf_pkg::POS_W'(brf_pkg::DEPTH));

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_dv_nxt    = out_dv_r;
    out_last_nxt  = out_last_r;
    out_acc_nxt   = out_acc_r;
    out_fill_nxt  = out_fill_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == brf_pkg::CMD_PUT) begin
            if (put_we) begin
              wp_nxt = wp_inc;
            end
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_dv_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
            out_acc_nxt   = put_we;
            out_fill_nxt  = brf_pkg::FILL_W'(put_we ? wp_inc - rp_r : fill_now);
          end else if (n_get == '0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_dv_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
            out_acc_nxt   = 1'b0;
            out_fill_nxt  = brf_pkg::FILL_W'(fill_now);
          end else begin
            cnt_nxt   = n_get;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_EM;
      end
      ST_EM: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rdata_r;
          out_dv_nxt    = 1'b1;
          out_acc_nxt   = 1'b0;
          out_last_nxt  = (cnt_r == brf_pkg::GET_W'(1));
          // drained: both positions go back to zero
          if (rp_inc == wp_r) begin
            rp_nxt       = '0;
            wp_nxt       = '0;
            out_fill_nxt = '0;
          end else begin
            rp_nxt       = rp_inc;
            out_fill_nxt = brf_pkg::FILL_W'(wp_r - rp_inc);
          end
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = (cnt_r == brf_pkg::GET_W'(1)) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (put_we) begin
      mem[wp_r[brf_pkg::ADDR_W-1:0]] <= din;
    end
    if (state_r == ST_RD) begin
      rdata_r <= mem[rp_r[brf_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_dv_r   <= out_dv_nxt;
    out_last_r <= out_last_nxt;
    out_acc_r  <= out_acc_nxt;
    out_fill_r <= out_fill_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_acc_r, out_dv_r};
  assign out_tdata  = {{brf_pkg::OUT_PAD_W{1'b0}},
                       (out_fill_r == brf_pkg::FILL_W'(brf_pkg::DEPTH)),
                       out_fill_r, out_data_r};

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import brf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              is_last;
    logic              accepted;
    logic [FILL_W-1:0] fill_count;
    logic              is_full;
  } fifo_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  // Shadow copy of the FIFO contents and positions
  logic [BYTE_W-1:0] model_store [DEPTH];
  logic [POS_W-1:0]  model_wr_pos;
  logic [POS_W-1:0]  model_rd_pos;

  fifo_result_t expected_out_q[$];

  int  err_count     = 0;
  int  idle_cycles   = 0;
  bit  tx_idle_en    = 1'b1;
  bit  rx_idle_en    = 1'b1;
  int  rx_hold_cycles = 0;

  byte_ring_fifo_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [POS_W-1:0] fifo_fill();
    return model_wr_pos - model_rd_pos;
  endfunction

  function automatic void push_result(logic [BYTE_W-1:0] data, logic valid, logic is_last,
                                      logic accepted);
    fifo_result_t r;
    r.data_out   = data;
    r.data_valid = valid;
    r.is_last    = is_last;
    r.accepted   = accepted;
    r.fill_count = fifo_fill();
    r.is_full    = (fifo_fill() == DEPTH);
    expected_out_q.push_back(r);
  endfunction

  function automatic void predict_fifo_op(logic cmd, logic [BYTE_W-1:0] din,
                                          logic [GET_W-1:0] cnt);
    int          n;
    logic        acc;
    logic [BYTE_W-1:0] b;
    if (cmd == CMD_PUT) begin
      acc = 1'b0;
      if (fifo_fill() != DEPTH) begin
        model_store[model_wr_pos[ADDR_W-1:0]] = din;
        model_wr_pos = model_wr_pos + 1'b1;
        acc = 1'b1;
      end
      push_result('0, 1'b0, 1'b1, acc);
    end else begin
      n = int'(cnt);
      if (n > MAX_GET) n = MAX_GET;
      if (n > fifo_fill()) n = int'(fifo_fill());
      if (n == 0) begin
        push_result('0, 1'b0, 1'b1, 1'b0);
      end else begin
        for (int i = 0; i < n; i++) begin
          b = model_store[model_rd_pos[ADDR_W-1:0]];
          model_rd_pos = model_rd_pos + 1'b1;
          // an emptied FIFO rewinds both positions
          if (model_rd_pos == model_wr_pos) begin
            model_rd_pos = '0;
            model_wr_pos = '0;
          end
          push_result(b, 1'b1, (i == n - 1), 1'b0);
        end
      end
    end
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      err_count++;
    end
  endfunction

  // Result checker and watchdog
  always @(posedge clk) begin
    fifo_result_t e;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_out_q.size() == 0) begin
          $error("unexpected result: data_out %0d fill_count %0d",
                 out_tdata[7:0], out_tdata[16:8]);
          err_count++;
        end else begin
          e = expected_out_q.pop_front();
          check_field("data_out",   int'(e.data_out),   int'(out_tdata[7:0]));
          check_field("fill_count", int'(e.fill_count), int'(out_tdata[16:8]));
          check_field("is_full",    int'(e.is_full),    int'(out_tdata[17]));
          check_field("data_valid", int'(e.data_valid), int'(out_tuser[0]));
          check_field("accepted",   int'(e.accepted),   int'(out_tuser[1]));
          check_field("last",       int'(e.is_last),    int'(out_tlast));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result sink: random stalls per item, or one long hold on request
  initial begin : result_sink
    int gap;
    out_tready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = rx_idle_en ? $urandom_range(0, 4) : 0;
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Entered and left at a falling edge; valid stays high across back-to-back items
  task automatic send_item(logic cmd, logic [BYTE_W-1:0] din, logic [GET_W-1:0] cnt);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, cnt, din};
    do @(posedge clk); while (!in_tready);
    predict_fifo_op(cmd, din, cnt);
    @(negedge clk);
  endtask

  task automatic put_byte(logic [BYTE_W-1:0] din);
    send_item(CMD_PUT, din, GET_W'($urandom_range(0, 127)));
  endtask

  task automatic get_bytes(logic [GET_W-1:0] cnt);
    send_item(CMD_GET, BYTE_W'($urandom_range(0, 255)), cnt);
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed_ops();
    get_bytes(7'd5);
    get_bytes(7'd0);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h5A);
    get_bytes(7'd0);
    get_bytes(7'd1);
    put_byte(8'hA5);
    // oversized request, limited by what is stored; empties the FIFO
    get_bytes(7'd127);
    put_byte(8'h80);
    get_bytes(7'd64);
    get_bytes(7'd2);
    put_byte(8'h7F);
    put_byte(8'h01);
    get_bytes(7'd65);
  endtask

  task automatic test_long_get();
    // store more than MAX_GET so the first request saturates
    repeat (MAX_GET + 1) put_byte(BYTE_W'($urandom_range(0, 255)));
    get_bytes(7'd127);
    get_bytes(7'd127);
  endtask

  task automatic test_output_stall();
    rx_hold_cycles = LONG_HOLD;
    repeat (10) begin
      if ($urandom_range(0, 2) != 0) put_byte(BYTE_W'($urandom_range(0, 255)));
      else get_bytes(GET_W'($urandom_range(0, 6)));
    end
  endtask

  task automatic test_random_mix(int num_items);
    for (int i = 0; i < num_items; i++) begin
      if (i % 8 == 0) begin
        tx_idle_en = 1'($urandom_range(0, 1));
        rx_idle_en = 1'($urandom_range(0, 1));
      end
      if (i == num_items / 2) wait_for_drain();
      if ($urandom_range(0, 99) < 58) begin
        put_byte(BYTE_W'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 3) != 0) begin
        get_bytes(GET_W'($urandom_range(0, 8)));
      end else begin
        get_bytes(GET_W'($urandom_range(0, 127)));
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_PUT;
    model_wr_pos = '0;
    model_rd_pos = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_ops();
    test_long_get();
    test_output_stall();
    test_random_mix(16);

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
